[hdl/gbmfe_pkg.sv]
package gbmfe_pkg;

    // Frame sync and message identifiers
    localparam logic [7:0] SYNC_A      = 8'hB5;
    localparam logic [7:0] SYNC_B      = 8'h62;
    localparam logic [7:0] CLS_NAV     = 8'h01;
    localparam logic [7:0] CLS_SEC     = 8'h27;
    localparam logic [7:0] ID_UNIQID   = 8'h03;
    localparam logic [7:0] ID_TIMEUTC  = 8'h21;
    localparam logic [7:0] ID_PVT      = 8'h07;
    localparam logic [7:0] ID_POSLLH   = 8'h02;

    // Frame position codes before the payload
    localparam logic [6:0] POS_HUNT    = 7'd0;
    localparam logic [6:0] POS_SYNC    = 7'd1;
    localparam logic [6:0] POS_CLASS   = 7'd2;
    localparam logic [6:0] POS_ID      = 7'd3;
    localparam logic [6:0] POS_PAYLOAD = 7'd4;

    // Message kinds
    localparam logic [1:0] KIND_UID  = 2'd0;
    localparam logic [1:0] KIND_UTC  = 2'd1;
    localparam logic [1:0] KIND_PVT  = 2'd2;
    localparam logic [1:0] KIND_LLH  = 2'd3;

    // Field codes
    localparam logic [4:0] FC_ID      = 5'd0;
    localparam logic [4:0] FC_YEAR    = 5'd1;
    localparam logic [4:0] FC_MONTH   = 5'd2;
    localparam logic [4:0] FC_DAY     = 5'd3;
    localparam logic [4:0] FC_HOUR    = 5'd4;
    localparam logic [4:0] FC_MIN     = 5'd5;
    localparam logic [4:0] FC_SEC     = 5'd6;
    localparam logic [4:0] FC_FIX     = 5'd7;
    localparam logic [4:0] FC_SATS    = 5'd8;
    localparam logic [4:0] FC_LON     = 5'd9;
    localparam logic [4:0] FC_LAT     = 5'd10;
    localparam logic [4:0] FC_HEIGHT  = 5'd11;
    localparam logic [4:0] FC_MSL     = 5'd12;
    localparam logic [4:0] FC_HACC    = 5'd13;
    localparam logic [4:0] FC_VACC    = 5'd14;
    localparam logic [4:0] FC_SPEED   = 5'd15;
    localparam logic [4:0] FC_HEADING = 5'd16;

    typedef struct packed {
        logic       hit;      // position lies inside a field
        logic [6:0] start;    // offset of the field's first byte
        logic [2:0] last_idx; // byte index of the field's last byte
        logic [4:0] code;
        logic       sgn;      // signed 32-bit field
        logic       last;     // final field of the kind
    } field_info_t;

    typedef struct packed {
        logic              valid;
        logic [4:0]        code;
        logic signed [40:0] value;
        logic [1:0]        kind;
    } result_t;

    function automatic field_info_t mk_field(input logic [6:0] start,
                                             input logic [2:0] last_idx,
                                             input logic [4:0] code,
                                             input logic sgn,
                                             input logic last);
        field_info_t f;
        f.hit      = 1'b1;
        f.start    = start;
        f.last_idx = last_idx;
        f.code     = code;
        f.sgn      = sgn;
        f.last     = last;
        return f;
    endfunction

    // Field layout of each message kind, offsets from the first sync byte
    function automatic field_info_t field_lookup(input logic [1:0] kind,
                                                 input logic [6:0] pos);
        field_info_t f;
        f = '0;
        case (kind)
            KIND_UID: begin
                case (pos) inside
                    [7'd10:7'd14]: f = mk_field(7'd10, 3'd4, FC_ID, 1'b0, 1'b1);
                    default:       f = '0;
                endcase
            end
            KIND_UTC: begin
                case (pos) inside
                    [7'd18:7'd19]: f = mk_field(7'd18, 3'd1, FC_YEAR, 1'b0, 1'b0);
                    7'd20:         f = mk_field(7'd20, 3'd0, FC_MONTH, 1'b0, 1'b0);
                    7'd21:         f = mk_field(7'd21, 3'd0, FC_DAY, 1'b0, 1'b0);
                    7'd22:         f = mk_field(7'd22, 3'd0, FC_HOUR, 1'b0, 1'b0);
                    7'd23:         f = mk_field(7'd23, 3'd0, FC_MIN, 1'b0, 1'b0);
                    7'd24:         f = mk_field(7'd24, 3'd0, FC_SEC, 1'b0, 1'b1);
                    default:       f = '0;
                endcase
            end
            KIND_PVT: begin
                case (pos) inside
                    [7'd10:7'd11]: f = mk_field(7'd10, 3'd1, FC_YEAR, 1'b0, 1'b0);
                    7'd12:         f = mk_field(7'd12, 3'd0, FC_MONTH, 1'b0, 1'b0);
                    7'd13:         f = mk_field(7'd13, 3'd0, FC_DAY, 1'b0, 1'b0);
                    7'd14:         f = mk_field(7'd14, 3'd0, FC_HOUR, 1'b0, 1'b0);
                    7'd15:         f = mk_field(7'd15, 3'd0, FC_MIN, 1'b0, 1'b0);
                    7'd16:         f = mk_field(7'd16, 3'd0, FC_SEC, 1'b0, 1'b0);
                    7'd26:         f = mk_field(7'd26, 3'd0, FC_FIX, 1'b0, 1'b0);
                    7'd29:         f = mk_field(7'd29, 3'd0, FC_SATS, 1'b0, 1'b0);
                    [7'd30:7'd33]: f = mk_field(7'd30, 3'd3, FC_LON, 1'b1, 1'b0);
                    [7'd34:7'd37]: f = mk_field(7'd34, 3'd3, FC_LAT, 1'b1, 1'b0);
                    [7'd38:7'd41]: f = mk_field(7'd38, 3'd3, FC_HEIGHT, 1'b1, 1'b0);
                    [7'd42:7'd45]: f = mk_field(7'd42, 3'd3, FC_MSL, 1'b1, 1'b0);
                    [7'd46:7'd49]: f = mk_field(7'd46, 3'd3, FC_HACC, 1'b0, 1'b0);
                    [7'd50:7'd53]: f = mk_field(7'd50, 3'd3, FC_VACC, 1'b0, 1'b0);
                    [7'd66:7'd69]: f = mk_field(7'd66, 3'd3, FC_SPEED, 1'b1, 1'b0);
                    [7'd70:7'd73]: f = mk_field(7'd70, 3'd3, FC_HEADING, 1'b1, 1'b1);
                    default:       f = '0;
                endcase
            end
            default: begin
                case (pos) inside
                    [7'd10:7'd13]: f = mk_field(7'd10, 3'd3, FC_LON, 1'b1, 1'b0);
                    [7'd14:7'd17]: f = mk_field(7'd14, 3'd3, FC_LAT, 1'b1, 1'b0);
                    [7'd18:7'd21]: f = mk_field(7'd18, 3'd3, FC_HEIGHT, 1'b1, 1'b0);
                    [7'd22:7'd25]: f = mk_field(7'd22, 3'd3, FC_MSL, 1'b1, 1'b0);
                    [7'd26:7'd29]: f = mk_field(7'd26, 3'd3, FC_HACC, 1'b0, 1'b0);
                    [7'd30:7'd33]: f = mk_field(7'd30, 3'd3, FC_VACC, 1'b0, 1'b1);
                    default:       f = '0;
                endcase
            end
        endcase
        return f;
    endfunction

    // Offset of the final byte of the final field of each kind
    function automatic logic [6:0] kind_end(input logic [1:0] kind);
        logic [6:0] e;
        case (kind)
            KIND_UID: e = 7'd14;
            KIND_UTC: e = 7'd24;
            KIND_PVT: e = 7'd73;
            default:  e = 7'd33;
        endcase
        return e;
    endfunction

endpackage

[hdl/gbmfe_parser.sv]
module gbmfe_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    output gbmfe_pkg::result_t  result
);

    logic [6:0]  pos_reg, pos_next;
    logic [1:0]  kind_reg, kind_next;
    logic        kind_valid_reg, kind_valid_next;
    logic [7:0]  class_reg, class_next;
    logic [39:0] acc_reg, acc_next;

    gbmfe_pkg::field_info_t finfo;
    logic [6:0]  pos_diff;
    logic [2:0]  byte_idx;
    logic [39:0] shifted;
    logic [39:0] acc_upd;
    logic        field_end;

    assign finfo     = gbmfe_pkg::field_lookup(kind_reg, pos_reg);
    assign pos_diff  = pos_reg - finfo.start;
    assign byte_idx  = pos_diff[2:0];
    assign shifted   = {32'd0, rx_byte} << {byte_idx, 3'b000};
    assign acc_upd   = (byte_idx == 3'd0) ? {32'd0, rx_byte} : (acc_reg | shifted);
    assign field_end = (byte_idx == finfo.last_idx);

    always_comb begin
        pos_next        = pos_reg;
        kind_next       = kind_reg;
        kind_valid_next = kind_valid_reg;
        class_next      = class_reg;
        acc_next        = acc_reg;
        result          = '0;
        case (pos_reg)
            gbmfe_pkg::POS_HUNT: begin
                if (rx_byte == gbmfe_pkg::SYNC_A) begin
                    pos_next = gbmfe_pkg::POS_SYNC;
                end
            end
            gbmfe_pkg::POS_SYNC: begin
                if (rx_byte == gbmfe_pkg::SYNC_B) begin
                    pos_next = gbmfe_pkg::POS_CLASS;
                end else if (rx_byte != gbmfe_pkg::SYNC_A) begin
                    pos_next        = gbmfe_pkg::POS_HUNT;
                    kind_valid_next = 1'b0;
                end
            end
            gbmfe_pkg::POS_CLASS: begin
                class_next = rx_byte;
                pos_next   = gbmfe_pkg::POS_ID;
            end
            gbmfe_pkg::POS_ID: begin
                pos_next        = gbmfe_pkg::POS_PAYLOAD;
                kind_valid_next = 1'b1;
                if (class_reg == gbmfe_pkg::CLS_SEC && rx_byte == gbmfe_pkg::ID_UNIQID) begin
                    kind_next = gbmfe_pkg::KIND_UID;
                end else if (class_reg == gbmfe_pkg::CLS_NAV &&
                             rx_byte == gbmfe_pkg::ID_TIMEUTC) begin
                    kind_next = gbmfe_pkg::KIND_UTC;
                end else if (class_reg == gbmfe_pkg::CLS_NAV &&
                             rx_byte == gbmfe_pkg::ID_PVT) begin
                    kind_next = gbmfe_pkg::KIND_PVT;
                end else if (class_reg == gbmfe_pkg::CLS_NAV &&
                             rx_byte == gbmfe_pkg::ID_POSLLH) begin
                    kind_next = gbmfe_pkg::KIND_LLH;
                end else begin
                    pos_next        = gbmfe_pkg::POS_HUNT;
                    kind_valid_next = 1'b0;
                end
            end
            default: begin
                if (!kind_valid_reg) begin
                    pos_next = gbmfe_pkg::POS_HUNT;
                end else if (finfo.hit) begin
                    acc_next = acc_upd;
                    pos_next = pos_reg + 7'd1;
                    if (field_end) begin
                        result.valid = 1'b1;
                        result.code  = finfo.code;
                        result.kind  = kind_reg;
                        result.value = finfo.sgn ? {{9{acc_upd[31]}}, acc_upd[31:0]}
                                                 : {1'b0, acc_upd};
                        if (finfo.last) begin
                            pos_next        = gbmfe_pkg::POS_HUNT;
                            kind_valid_next = 1'b0;
                        end
                    end
                end else if (pos_reg >= gbmfe_pkg::kind_end(kind_reg)) begin
                    pos_next        = gbmfe_pkg::POS_HUNT;
                    kind_valid_next = 1'b0;
                end else begin
                    pos_next = pos_reg + 7'd1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= gbmfe_pkg::POS_HUNT;
            kind_reg       <= gbmfe_pkg::KIND_UID;
            kind_valid_reg <= 1'b0;
            class_reg      <= 8'd0;
            acc_reg        <= 40'd0;
        end else if (step) begin
            pos_reg        <= pos_next;
            kind_reg       <= kind_next;
            kind_valid_reg <= kind_valid_next;
            class_reg      <= class_next;
            acc_reg        <= acc_next;
        end
    end

endmodule

[hdl/gnss_binary_message_field_extractor.sv]
// Datapath: a byte accepted on the input channel is held in the input
//   register, then parsed into the result register; while a result is
//   stalled, the held byte waits in the input register.
// Throughput: one byte per cycle while the result channel is not stalled.
// Reset: aresetn is synchronous, active low; clears the valid flags of both
//   register stages and returns the parser to hunting for the sync pair.
module gnss_binary_message_field_extractor (
    input  logic               aclk,
    input  logic               aresetn,
    // byte input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    // field result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [4:0]         m_field_code,
    output logic signed [40:0] m_field_value,
    output logic [1:0]         m_message_kind
);

    // Input stage: one byte holding register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    // Output stage: result register
    logic               out_valid_reg, out_valid_next;
    logic [4:0]         out_code_reg;
    logic signed [40:0] out_value_reg;
    logic [1:0]         out_kind_reg;

    logic               advance;
    gbmfe_pkg::result_t result;

    // A held byte moves into the parser whenever the result register is free
    // or is being emptied this cycle. Bytes that produce no result still
    // advance, so the result register only ever holds real results.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = result.valid;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Frame tracking and field assembly
    gbmfe_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (advance && result.valid) begin
            out_code_reg  <= result.code;
            out_value_reg <= result.value;
            out_kind_reg  <= result.kind;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_field_code   = out_code_reg;
    assign m_field_value  = out_value_reg;
    assign m_message_kind = out_kind_reg;

endmodule

[hdl/gbmfe_props.sv]
module gbmfe_props (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [4:0]         m_field_code,
    input logic signed [40:0] m_field_value,
    input logic [1:0]         m_message_kind
);

    // No result transaction right after a reset cycle
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_field_code) &&
            $stable(m_field_value) && $stable(m_message_kind))
        else $error("result changed while stalled");

    // The id field belongs only to the unique-id message
    a_id_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_field_code == gbmfe_pkg::FC_ID |->
            m_message_kind == gbmfe_pkg::KIND_UID)
        else $error("id field with wrong message kind");

    // Byte-wide fields carry no bits above the byte
    a_byte_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_field_code == gbmfe_pkg::FC_MONTH ||
                    m_field_code == gbmfe_pkg::FC_DAY ||
                    m_field_code == gbmfe_pkg::FC_HOUR ||
                    m_field_code == gbmfe_pkg::FC_MIN ||
                    m_field_code == gbmfe_pkg::FC_SEC ||
                    m_field_code == gbmfe_pkg::FC_FIX ||
                    m_field_code == gbmfe_pkg::FC_SATS) |->
            m_field_value[40:8] == 33'd0)
        else $error("byte field value out of range");

endmodule

bind gnss_binary_message_field_extractor gbmfe_props u_props (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_field_code   (m_field_code),
    .m_field_value  (m_field_value),
    .m_message_kind (m_message_kind)
);
